/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

/* src/npc_pkg.sv */
// Shared types and decode constants for the next-PC resolver.
package npc_pkg;

  localparam logic [15:0] C_J_MASK    = 16'hE003;
  localparam logic [15:0] C_J_MATCH   = 16'hA001;
  localparam logic [15:0] C_JR_MASK   = 16'hE07F;
  localparam logic [15:0] C_JR_MATCH  = 16'h8002;
  localparam logic [15:0] C_BR_MASK   = 16'hC003;
  localparam logic [15:0] C_BR_MATCH  = 16'hC001;
  localparam logic [6:0]  OPC_MASK    = 7'h7F;
  localparam logic [6:0]  OPC_JAL     = 7'h6F;
  localparam logic [6:0]  OPC_BRANCH  = 7'h63;
  localparam logic [6:0]  OPC_OP      = 7'h33;
  localparam logic [31:0] JALR_MASK   = 32'h0000_707F;
  localparam logic [31:0] JALR_MATCH  = 32'h0000_0067;
  localparam logic [1:0]  LEN32_CODE  = 2'b11;

  localparam logic [2:0]  F3_BEQ      = 3'd0;
  localparam logic [2:0]  F3_BNE      = 3'd1;
  localparam logic [2:0]  F3_BLT      = 3'd4;
  localparam logic [2:0]  F3_BGE      = 3'd5;
  localparam logic [2:0]  F3_BLTU     = 3'd6;
  localparam logic [2:0]  F3_BGEU     = 3'd7;

  typedef enum logic [2:0] {
    KIND_SEQ,
    KIND_PC_REL,
    KIND_REG,
    KIND_JALR,
    KIND_BRANCH
  } npc_kind_t;

  typedef enum logic [2:0] {
    CMP_EQ,
    CMP_NE,
    CMP_LT,
    CMP_GE,
    CMP_LTU,
    CMP_GEU
  } npc_cmp_t;

  typedef struct packed {
    npc_kind_t   kind;
    npc_cmp_t    cmp;
    logic        is_comp;
    logic [63:0] imm;
    logic [63:0] pc;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } npc_dec_t;

  typedef struct packed {
    logic        redirect;
    logic        clear_lsb;
    logic [63:0] target;
    logic [63:0] seq;
  } npc_exe_t;

endpackage

/* src/npc_decode.sv */
// Stage 1: instruction decode, immediate extraction and operand selection.
module npc_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          instruction,
  input  logic [63:0]          current_pc,
  input  logic [63:0]          rs1_value,
  input  logic [63:0]          rs2_value,
  output logic                 dec_valid,
  output npc_pkg::npc_dec_t    dec
);

  npc_pkg::npc_dec_t dec_next;
  logic [15:0]       half;

  assign half = instruction[15:0];

  always_comb begin
    dec_next         = '0;
    dec_next.kind    = npc_pkg::KIND_SEQ;
    dec_next.cmp     = npc_pkg::CMP_EQ;
    dec_next.pc      = current_pc;
    dec_next.is_comp = (instruction[1:0] != npc_pkg::LEN32_CODE);
    if (dec_next.is_comp) begin
      // compressed branches test the register against zero
      dec_next.op_a = rs1_value;
      dec_next.op_b = '0;
      if ((half & npc_pkg::C_J_MASK) == npc_pkg::C_J_MATCH) begin
        dec_next.kind = npc_pkg::KIND_PC_REL;
        dec_next.imm  = {{52{half[12]}}, half[12], half[8], half[10:9], half[6],
                         half[7], half[2], half[11], half[5:3], 1'b0};
      end else if ((half & npc_pkg::C_JR_MASK) == npc_pkg::C_JR_MATCH) begin
        // rs1 of x0 is C.EBREAK or reserved: fall through
        if (half[11:7] != 5'd0) begin
          dec_next.kind = npc_pkg::KIND_REG;
        end
      end else if ((half & npc_pkg::C_BR_MASK) == npc_pkg::C_BR_MATCH) begin
        dec_next.kind = npc_pkg::KIND_BRANCH;
        dec_next.cmp  = half[13] ? npc_pkg::CMP_NE : npc_pkg::CMP_EQ;
        dec_next.imm  = {{55{half[12]}}, half[12], half[6:5], half[2], half[11:10],
                         half[4:3], 1'b0};
      end
    end else begin
      // x0 reads as zero
      dec_next.op_a = (instruction[19:15] == 5'd0) ? 64'd0 : rs1_value;
      dec_next.op_b = (instruction[24:20] == 5'd0) ? 64'd0 : rs2_value;
      if ((instruction[6:0] & npc_pkg::OPC_MASK) == npc_pkg::OPC_JAL) begin
        dec_next.kind = npc_pkg::KIND_PC_REL;
        dec_next.imm  = {{43{instruction[31]}}, instruction[31], instruction[19:12],
                         instruction[20], instruction[30:21], 1'b0};
      end else if ((instruction & npc_pkg::JALR_MASK) == npc_pkg::JALR_MATCH) begin
        dec_next.kind = npc_pkg::KIND_JALR;
        dec_next.imm  = {{52{instruction[31]}}, instruction[31:20]};
      end else if ((instruction[6:0] & npc_pkg::OPC_MASK) == npc_pkg::OPC_BRANCH) begin
        dec_next.imm  = {{51{instruction[31]}}, instruction[31], instruction[7],
                         instruction[30:25], instruction[11:8], 1'b0};
        dec_next.kind = npc_pkg::KIND_BRANCH;
        case (instruction[14:12])
          npc_pkg::F3_BEQ:  dec_next.cmp = npc_pkg::CMP_EQ;
          npc_pkg::F3_BNE:  dec_next.cmp = npc_pkg::CMP_NE;
          npc_pkg::F3_BLT:  dec_next.cmp = npc_pkg::CMP_LT;
          npc_pkg::F3_BGE:  dec_next.cmp = npc_pkg::CMP_GE;
          npc_pkg::F3_BLTU: dec_next.cmp = npc_pkg::CMP_LTU;
          npc_pkg::F3_BGEU: dec_next.cmp = npc_pkg::CMP_GEU;
          default:          dec_next.kind = npc_pkg::KIND_SEQ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

endmodule

/* src/npc_exec.sv */
// Stage 2: branch compare, target add and fall-through add.
module npc_exec (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dec_valid,
  input  npc_pkg::npc_dec_t    dec,
  output logic                 exe_valid,
  output npc_pkg::npc_exe_t    exe
);

  npc_pkg::npc_exe_t exe_next;
  logic              taken;
  logic [63:0]       base;

  always_comb begin
    case (dec.cmp)
      npc_pkg::CMP_EQ:  taken = (dec.op_a == dec.op_b);
      npc_pkg::CMP_NE:  taken = (dec.op_a != dec.op_b);
      npc_pkg::CMP_LT:  taken = ($signed(dec.op_a) < $signed(dec.op_b));
      npc_pkg::CMP_GE:  taken = ($signed(dec.op_a) >= $signed(dec.op_b));
      npc_pkg::CMP_LTU: taken = (dec.op_a < dec.op_b);
      npc_pkg::CMP_GEU: taken = (dec.op_a >= dec.op_b);
      default:          taken = 1'b0;
    endcase
  end

  always_comb begin
    base = ((dec.kind == npc_pkg::KIND_JALR) || (dec.kind == npc_pkg::KIND_REG))
           ? dec.op_a : dec.pc;
    exe_next.target    = base + dec.imm;
    exe_next.seq       = dec.pc + (dec.is_comp ? 64'd2 : 64'd4);
    exe_next.clear_lsb = (dec.kind == npc_pkg::KIND_JALR);
    case (dec.kind)
      npc_pkg::KIND_SEQ:    exe_next.redirect = 1'b0;
      npc_pkg::KIND_BRANCH: exe_next.redirect = taken;
      default:              exe_next.redirect = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
    end else begin
      exe_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    exe <= exe_next;
  end

endmodule

/* src/riscv_next_pc_resolver.sv */
// Top level of the next-PC resolver: three-stage pipeline and result register.
// Path: an accepted word passes through three register stages (decode,
//   compare/add, select) and then appears on next_pc with done high.
// Throughput: one word per cycle; busy is never raised since no stage can stall.
// Reset: synchronous rst clears the stage valid bits, so done stays low until
//   a word started after reset reaches the output; data registers are not reset.
// The receiver cannot stall: each next_pc is shown for exactly one cycle.
`include "assert_macros.svh"

module riscv_next_pc_resolver (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction,
  input  logic [63:0] current_pc,
  input  logic [63:0] rs1_value,
  input  logic [63:0] rs2_value,
  output logic        done,
  output logic [63:0] next_pc
);

  logic              in_valid;
  logic              dec_valid;
  npc_pkg::npc_dec_t dec;
  logic              exe_valid;
  npc_pkg::npc_exe_t exe;
  logic [63:0]       next_pc_next;

  // Every stage advances every cycle, so a new word is always welcome.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // Stage 1: decode the word, pick operands, build the immediate.
  npc_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .instruction (instruction),
    .current_pc  (current_pc),
    .rs1_value   (rs1_value),
    .rs2_value   (rs2_value),
    .dec_valid   (dec_valid),
    .dec         (dec)
  );

  // Stage 2: resolve the branch and form both candidate addresses.
  npc_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec       (dec),
    .exe_valid (exe_valid),
    .exe       (exe)
  );

  // Stage 3: choose target or fall-through; drop bit 0 for JALR.
  always_comb begin
    if (exe.redirect) begin
      next_pc_next = exe.target & ~{63'd0, exe.clear_lsb};
    end else begin
      next_pc_next = exe.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exe_valid;
    end
  end

  always_ff @(posedge clk) begin
    next_pc <= next_pc_next;
  end

  `ASSERT_CLK_RST(a_done_follows_start, clk, rst, in_valid |-> ##3 done, "accepted word did not complete in three cycles")
  `ASSERT_CLK_RST(a_done_has_source, clk, rst, done |-> $past(in_valid, 3), "done raised with no word accepted three cycles earlier")
  `ASSERT_CLK_RST(a_jalr_lsb_clear, clk, rst, (in_valid && (instruction[1:0] == npc_pkg::LEN32_CODE) && ((instruction & npc_pkg::JALR_MASK) == npc_pkg::JALR_MATCH)) |-> ##3 !next_pc[0], "JALR target kept bit 0")
  `ASSERT_CLK_RST(a_alu_op_sequential, clk, rst, (in_valid && (instruction[6:0] == npc_pkg::OPC_OP)) |-> ##3 (next_pc == $past(current_pc, 3) + 64'd4), "register ALU op did not fall through to pc+4")
  `ASSERT_CLK(a_no_done_after_reset, clk, $past(rst) |-> !done, "done raised right after reset")

endmodule
